### design/mrtu_pkg.sv
// shared constants, codes and the crc byte update for the modbus rtu receiver
// no dependencies; imported by modbus_rtu_frame_receiver_unit

package mrtu_pkg;

	localparam int BUF_BYTES_DEF = 16;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] STATION_RESET = 8'd1;
	localparam logic [4:0] GAP_RESET     = 5'd15;

	// input item codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_STATION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP     = 1'd1;

	// reply kinds
	localparam logic [1:0] REPLY_NONE = 2'd0;
	localparam logic [1:0] REPLY_0101 = 2'd1;
	localparam logic [1:0] REPLY_0301 = 2'd2;

	localparam logic [7:0] FC_REG_HI_A = 8'h01;
	localparam logic [7:0] FC_REG_HI_B = 8'h03;
	localparam logic [7:0] FC_REG_LO   = 8'h01;

	// reflected crc-16, eight shift steps per byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### design/modbus_rtu_frame_receiver_unit.sv
// modbus rtu frame receiver: byte buffer, crc-16 check and frame end on line silence
// depends on mrtu_pkg
//
// usage:
//   input channel (in_valid/in_ready) carries one item per accept: opcode 0 is a
//   received byte in rx_byte, opcode 1 is one timer tick. a frame ends on the tick
//   that makes the quiet count exceed gap_ticks; that tick yields one result item
//   on the output channel (out_valid/out_ready) with crc, address and header info.
//   configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   station_address (index 0) or gap_ticks (index 1); it is always ready.
// timing:
//   an item is held in the input register and its state update happens as it
//   leaves that register, so a result is written to the result register when
//   its tick leaves the input register. one item per cycle is taken in steady
//   flow; the crc update is eight shift steps done combinationally.
// reset: frame state clears, station_address becomes 1 and gap_ticks 15.
// stall: while a result waits, bytes and ticks that end no frame keep flowing;
//   an item that would end a frame holds in the input register, and in_ready
//   drops until the waiting result is taken.

module modbus_rtu_frame_receiver_unit #(
	parameter int BUF_BYTES = mrtu_pkg::BUF_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           opcode,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           crc_ok,
	output logic                           addressed,
	output logic [7:0]                     function_code,
	output logic [7:0]                     reg_high,
	output logic [7:0]                     reg_low,
	output logic [4:0]                     frame_length,
	output logic                           overflow,
	output logic [1:0]                     reply_kind,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mrtu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);
	import mrtu_pkg::*;

	localparam int CW = $clog2(BUF_BYTES + 1);

	// configuration
	logic [7:0]  station_q;
	logic [4:0]  gap_q;

	// input register
	logic        valid_s1;
	logic        opcode_s1;
	logic [7:0]  byte_s1;

	// frame state
	logic [CW-1:0] count_q;
	logic [15:0]   crc_q;
	logic [15:0]   last_q;
	logic [7:0]    head_q [4];
	logic [4:0]    silence_q;
	logic          fresh_q;
	logic          ovf_q;

	// result register
	logic        out_valid_q;
	logic        crc_ok_q;
	logic        addressed_q;
	logic [7:0]  fc_q;
	logic [7:0]  reg_high_q;
	logic [7:0]  reg_low_q;
	logic [4:0]  length_q;
	logic        ovf_out_q;
	logic [1:0]  kind_q;

	logic        frame_end;
	logic        adv_s1;
	logic [5:0]  silence_next;
	logic        crc_match;
	logic        addr_match;
	logic [1:0]  kind_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= STATION_RESET;
			gap_q     <= GAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_STATION: station_q <= cfg_data;
				CFG_GAP:     gap_q     <= cfg_data[4:0];
				default:     ;
			endcase
		end
	end

	assign silence_next = {1'b0, silence_q} + 6'd1;
	assign frame_end = valid_s1 && (opcode_s1 == OP_TICK) && (count_q != '0) && !fresh_q
		&& (silence_next > {1'b0, gap_q});
	// only an item that ends a frame needs room in the result register
	assign adv_s1 = valid_s1 && (!frame_end || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			byte_s1   <= rx_byte;
		end
	end

	assign crc_match = (count_q >= CW'(4)) && (crc_q[7:0] == last_q[15:8])
		&& (crc_q[15:8] == last_q[7:0]);
	assign addr_match = (head_q[0] == station_q);

	always_comb begin
		kind_next = REPLY_NONE;
		if (crc_match && addr_match && head_q[3] == FC_REG_LO) begin
			priority if (head_q[2] == FC_REG_HI_A) begin
				kind_next = REPLY_0101;
			end else if (head_q[2] == FC_REG_HI_B) begin
				kind_next = REPLY_0301;
			end else begin
				kind_next = REPLY_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			crc_q     <= CRC_INIT;
			last_q    <= '0;
			head_q    <= '{default: 8'h00};
			silence_q <= '0;
			fresh_q   <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (adv_s1) begin
			if (opcode_s1 == OP_BYTE) begin
				fresh_q <= 1'b1;
				if (count_q >= CW'(BUF_BYTES)) begin
					ovf_q <= 1'b1;
				end else begin
					// the two newest bytes stay out of the crc until a later byte arrives
					if (count_q >= CW'(2)) begin
						crc_q <= crc_byte(crc_q, last_q[15:8]);
					end
					last_q <= {last_q[7:0], byte_s1};
					if (count_q < CW'(4)) begin
						head_q[count_q[1:0]] <= byte_s1;
					end
					count_q <= count_q + CW'(1);
				end
			end else if (count_q == '0 || fresh_q) begin
				silence_q <= '0;
				fresh_q   <= 1'b0;
			end else if (!frame_end) begin
				silence_q <= silence_next[4:0];
			end else begin
				count_q   <= '0;
				crc_q     <= CRC_INIT;
				last_q    <= '0;
				head_q    <= '{default: 8'h00};
				silence_q <= '0;
				fresh_q   <= 1'b0;
				ovf_q     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && frame_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && frame_end) begin
			crc_ok_q    <= crc_match;
			addressed_q <= addr_match;
			fc_q        <= head_q[1];
			reg_high_q  <= head_q[2];
			reg_low_q   <= head_q[3];
			length_q    <= 5'(count_q);
			ovf_out_q   <= ovf_q;
			kind_q      <= kind_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign crc_ok        = crc_ok_q;
	assign addressed     = addressed_q;
	assign function_code = fc_q;
	assign reg_high      = reg_high_q;
	assign reg_low       = reg_low_q;
	assign frame_length  = length_q;
	assign overflow      = ovf_out_q;
	assign reply_kind    = kind_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(BUF_BYTES))
		else $error("byte count beyond buffer size");

	a_fresh_needs_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q |-> (count_q != '0))
		else $error("fresh byte flag with empty buffer");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && frame_end) |=> (count_q == '0 && out_valid_q))
		else $error("frame end did not clear state or raise result");

	a_reply_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (kind_q == REPLY_NONE || (crc_ok_q && addressed_q)))
		else $error("reply kind without crc and address match");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(adv_s1 && frame_end))
		else $error("waiting result overwritten");
`endif

endmodule
